// ===== hdl/jsrm_pkg.sv =====
// jsrm_pkg: types and constants shared by the json string region mask blocks
// no dependencies

package jsrm_pkg;

  localparam int unsigned BlockBits = 64;
  localparam int unsigned QueueDepth = 2;

  localparam logic [BlockBits-1:0] EvenPos = 64'h5555_5555_5555_5555;
  localparam logic [BlockBits-1:0] OddPos  = 64'hAAAA_AAAA_AAAA_AAAA;

  // one resolved variant of a block, for a given incoming odd run carry
  typedef struct packed {
    logic [BlockBits-1:0] in_string;
    logic [BlockBits-1:0] real_q;
    logic                 odd_last;
  } jsrm_variant_t;

  // classified block, waiting for the carries to be applied
  typedef struct packed {
    logic [BlockBits-1:0] structural;
    jsrm_variant_t        no_carry;
    jsrm_variant_t        with_carry;
  } jsrm_item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } jsrm_qstat_t;

endpackage

// ===== hdl/jsrm_front.sv =====
// jsrm_front: classifies one block into both odd run carry variants
// depends on jsrm_pkg

module jsrm_front (
  input  logic [jsrm_pkg::BlockBits-1:0] structural_bits_i,
  input  logic [jsrm_pkg::BlockBits-1:0] quote_bits_i,
  input  logic [jsrm_pkg::BlockBits-1:0] backslash_bits_i,
  output jsrm_pkg::jsrm_item_t           item_o
);
  import jsrm_pkg::*;

  function automatic logic [BlockBits-1:0] prefix_xor(input logic [BlockBits-1:0] v);
    logic [BlockBits-1:0] r;
    r = v;
    for (int s = 1; s < BlockBits; s = s * 2) begin
      r = r ^ (r << s);
    end
    return r;
  endfunction

  logic [BlockBits-1:0] bs;
  logic [BlockBits-1:0] heads;
  logic [BlockBits-1:0] span_e;
  logic [BlockBits-1:0] span_o;
  logic [BlockBits-1:0] odd0;
  logic [BlockBits-1:0] odd1;
  logic [BlockBits-1:0] lead;
  logic [BlockBits-1:0] real_q0;
  logic [BlockBits-1:0] real_q1;

  always_comb begin
    bs      = backslash_bits_i;
    heads   = bs & ~(bs << 1);
    span_e  = bs & ((bs + (heads & EvenPos)) ^ bs);
    span_o  = bs & ((bs + (heads & OddPos)) ^ bs);
    odd0    = (span_e & EvenPos) | (span_o & OddPos);
    lead    = bs & ~(bs + {{(BlockBits-1){1'b0}}, 1'b1});
    odd1    = bs[0] ? (odd0 ^ lead) : odd0;
    real_q0 = quote_bits_i & ~(odd0 << 1);
    real_q1 = quote_bits_i & ~((odd1 << 1) | {{(BlockBits-1){1'b0}}, 1'b1});

    item_o.structural           = structural_bits_i;
    item_o.no_carry.in_string   = prefix_xor(real_q0);
    item_o.no_carry.real_q      = real_q0;
    item_o.no_carry.odd_last    = odd0[BlockBits-1];
    item_o.with_carry.in_string = prefix_xor(real_q1);
    item_o.with_carry.real_q    = real_q1;
    item_o.with_carry.odd_last  = odd1[BlockBits-1];
  end

endmodule

// ===== hdl/jsrm_queue.sv =====
// jsrm_queue: two entry queue between the classifier and the carry stage
// depends on jsrm_pkg

module jsrm_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  jsrm_pkg::jsrm_item_t   item_i,
  input  logic                   pop_i,
  output jsrm_pkg::jsrm_item_t   item_o,
  output jsrm_pkg::jsrm_qstat_t  stat_o
);
  import jsrm_pkg::*;

  jsrm_item_t entries_q [QueueDepth];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push;
  logic       do_pop;

  assign stat_o.valid = (cnt_q != 2'd0);
  assign stat_o.full  = (cnt_q == 2'(QueueDepth));
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && stat_o.valid;
  assign item_o       = entries_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_q] <= item_i;
    end
  end

endmodule

// ===== hdl/jsrm_back.sv =====
// jsrm_back: applies the carries, masks the structural bits, holds the result
// depends on jsrm_pkg

module jsrm_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  jsrm_pkg::jsrm_item_t                item_i,
  input  logic                                item_valid_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [jsrm_pkg::BlockBits-1:0]      structural_outside_strings_o,
  output logic                                ends_inside_string_o
);
  import jsrm_pkg::*;

  logic                 odd_carry_q, odd_carry_d;
  logic                 str_carry_q, str_carry_d;
  logic                 valid_q, valid_d;
  logic [BlockBits-1:0] mask_q, mask_d;
  logic                 end_q, end_d;
  jsrm_variant_t        sel;
  logic [BlockBits-1:0] in_string;

  assign pop_o = item_valid_i && (!valid_q || !out_stall_i);

  always_comb begin
    sel       = odd_carry_q ? item_i.with_carry : item_i.no_carry;
    in_string = sel.in_string ^ {BlockBits{str_carry_q}};
    mask_d    = item_i.structural & ~(in_string & ~sel.real_q);
    end_d     = in_string[BlockBits-1];
    odd_carry_d = pop_o ? sel.odd_last : odd_carry_q;
    str_carry_d = pop_o ? end_d : str_carry_q;
    valid_d     = pop_o || (valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      odd_carry_q <= 1'b0;
      str_carry_q <= 1'b0;
      valid_q     <= 1'b0;
    end else begin
      odd_carry_q <= odd_carry_d;
      str_carry_q <= str_carry_d;
      valid_q     <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      mask_q <= mask_d;
      end_q  <= end_d;
    end
  end

  assign out_valid_o                  = valid_q;
  assign structural_outside_strings_o = mask_q;
  assign ends_inside_string_o         = end_q;

endmodule

// ===== hdl/json_string_region_mask.sv =====
// json_string_region_mask: top level, clears structural bits inside json strings
// depends on jsrm_pkg, jsrm_front, jsrm_queue, jsrm_back

// One 64-byte block is taken per cycle while in_stall_o is low; it is written
// to the queue and its result is then loaded into the output register: the
// classifier resolves escapes and the in-string prefix xor for both values of
// the incoming odd run carry in the accepting cycle and writes a two entry
// queue; the carry stage then picks the variant, applies the string carry and
// loads the output register, updating both carries in the same cycle so blocks
// follow back to back.
// in_stall_o rises only when the queue is full behind a stalled output.

module json_string_region_mask (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [jsrm_pkg::BlockBits-1:0]    structural_bits_i,
  input  logic [jsrm_pkg::BlockBits-1:0]    quote_bits_i,
  input  logic [jsrm_pkg::BlockBits-1:0]    backslash_bits_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [jsrm_pkg::BlockBits-1:0]    structural_outside_strings_o,
  output logic                              ends_inside_string_o
);
  import jsrm_pkg::*;

  jsrm_item_t  front_item;
  jsrm_item_t  queue_item;
  jsrm_qstat_t qstat;
  logic        pop;
  logic        push;

  assign in_stall_o = qstat.full;
  assign push       = in_valid_i && !qstat.full;

  jsrm_front u_front (
    .structural_bits_i (structural_bits_i),
    .quote_bits_i      (quote_bits_i),
    .backslash_bits_i  (backslash_bits_i),
    .item_o            (front_item)
  );

  jsrm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .item_o (queue_item),
    .stat_o (qstat)
  );

  jsrm_back u_back (
    .clk_i                        (clk_i),
    .rst_ni                       (rst_ni),
    .item_i                       (queue_item),
    .item_valid_i                 (qstat.valid),
    .pop_o                        (pop),
    .out_valid_o                  (out_valid_o),
    .out_stall_i                  (out_stall_i),
    .structural_outside_strings_o (structural_outside_strings_o),
    .ends_inside_string_o         (ends_inside_string_o)
  );

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.full |-> qstat.valid)
    else $error("queue full while empty");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> qstat.valid || out_valid_o)
    else $error("accepted request vanished");

  a_idle_output_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.valid && !out_valid_o |-> pop)
    else $error("queued request not moved to empty output");

  a_full_only_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.full |-> out_valid_o)
    else $error("queue full without a pending result");

endmodule
